// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/hdfh_pkg.sv -----
// ---------------------------------------------------------------------------
// hdfh_pkg
// Types and constants of the humidity-difference fan controller.
// ---------------------------------------------------------------------------
package hdfh_pkg;

	// Field widths.
	localparam int HUM_W      = 14;
	localparam int THR_W      = 14;
	localparam int TICKS_W    = 17;
	localparam int DUTY_W     = 8;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_READING = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EVAL    = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_IN_STALE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OUT_STALE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ON_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY    = 2'd3;

	// Configuration reset values.
	localparam logic [THR_W-1:0]   ON_THR_RST  = 14'd500;
	localparam logic [THR_W-1:0]   OFF_THR_RST = 14'd400;
	localparam logic [TICKS_W-1:0] TIMEOUT_RST = 17'd60000;
	localparam logic [DUTY_W-1:0]  DUTY_RST    = 8'd125;

	// Sensor indexes.
	localparam int SNS_OUTDOOR = 0;
	localparam int SNS_INDOOR  = 1;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             sensor_sel;
		logic             reading_valid;
		logic [HUM_W-1:0] humidity;
	} in_t;

	typedef struct packed {
		logic                fan_running;
		logic [DUTY_W-1:0]   fan_duty;
		logic [STATUS_W-1:0] status;
		logic                outdoor_fresh;
		logic                indoor_fresh;
	} out_t;

	typedef struct packed {
		logic [THR_W-1:0]   on_threshold;
		logic [THR_W-1:0]   off_threshold;
		logic [TICKS_W-1:0] timeout_ticks;
		logic [DUTY_W-1:0]  run_duty;
	} cfg_t;

endpackage

// ----- hdl/humidity_diff_fan_hysteresis_top.sv -----
// ---------------------------------------------------------------------------
// humidity_diff_fan_hysteresis_top
// Fan controller with on/off hysteresis on indoor minus outdoor humidity.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid / in_stall / in_data: a sensor reading, a
// one-millisecond tick, or an evaluate command. Only evaluate produces a
// result, on out_valid / out_stall / out_data; other commands only update
// the sensor state.
// A request is registered in the input register on acceptance and
// processed from there; an evaluate result is registered in the result
// register and presented on out_valid until it is taken.
// Throughput is one request per cycle while in_stall is low; each request
// reads and updates the sensor state as it leaves stage one, so back-to-back
// requests see each other's effects in order.
// The result register decouples the sides: while a result waits on
// out_stall, readings and ticks still flow; an evaluate request waits in
// the input register and in_stall rises until the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once and
// belong to quiet periods.
// Reset clears both sensors to never seen, the ages to zero, the fan to
// off, the registers to their defaults, and empties both stage registers.
// ---------------------------------------------------------------------------
module humidity_diff_fan_hysteresis_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  hdfh_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output hdfh_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [hdfh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdfh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hdfh_pkg::*;

	cfg_t cfg;

	in_t  req_s1;
	logic req_valid_s1;

	logic               seen_q  [2];
	logic [TICKS_W-1:0] age_q   [2];
	logic [HUM_W-1:0]   hum_q   [2];
	logic               fan_q;

	out_t res_s2;
	logic res_valid_s2;

	logic            adv_s1;
	logic            do_s1;
	logic            is_eval_s1;
	logic            out_ok;
	logic            in_ok;
	logic signed [HUM_W:0] diff;
	logic signed [HUM_W:0] on_thr_s;
	logic signed [HUM_W:0] off_thr_s;
	logic            fan_next;
	logic [STATUS_W-1:0] status_next;

	hdfh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage one holds only while an evaluate request faces a full, stalled result.
	assign is_eval_s1 = req_valid_s1 && (req_s1.cmd == CMD_EVAL);
	assign adv_s1     = !(is_eval_s1 && res_valid_s2 && out_stall);
	assign do_s1      = req_valid_s1 && adv_s1;
	assign in_stall   = !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			req_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_s1 <= in_data;
		end
	end

	// Freshness and hysteresis decision.
	assign out_ok    = seen_q[SNS_OUTDOOR] && (age_q[SNS_OUTDOOR] < cfg.timeout_ticks);
	assign in_ok     = seen_q[SNS_INDOOR] && (age_q[SNS_INDOOR] < cfg.timeout_ticks);
	assign diff      = signed'({1'b0, hum_q[SNS_INDOOR]}) - signed'({1'b0, hum_q[SNS_OUTDOOR]});
	assign on_thr_s  = signed'({1'b0, cfg.on_threshold});
	assign off_thr_s = signed'({1'b0, cfg.off_threshold});

	always_comb begin
		fan_next = fan_q;
		if (in_ok && out_ok) begin
			if (!fan_q && (diff >= on_thr_s)) begin
				fan_next = 1'b1;
			end else if (fan_q && (diff <= off_thr_s)) begin
				fan_next = 1'b0;
			end
		end else begin
			fan_next = 1'b0;
		end
	end

	always_comb begin
		if (!seen_q[SNS_OUTDOOR] || !seen_q[SNS_INDOOR]) begin
			status_next = ST_MISSING;
		end else if (!in_ok && !out_ok) begin
			status_next = ST_MISSING;
		end else if (!in_ok) begin
			status_next = ST_IN_STALE;
		end else if (!out_ok) begin
			status_next = ST_OUT_STALE;
		end else if (fan_next) begin
			status_next = ST_RUNNING;
		end else begin
			status_next = ST_STOPPED;
		end
	end

	// Sensor state and fan state, updated as each request leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				seen_q[i] <= 1'b0;
				age_q[i]  <= '0;
				hum_q[i]  <= '0;
			end
			fan_q <= 1'b0;
		end else if (do_s1) begin
			case (req_s1.cmd)
				CMD_READING: begin
					if (req_s1.reading_valid) begin
						hum_q[req_s1.sensor_sel]  <= req_s1.humidity;
						seen_q[req_s1.sensor_sel] <= 1'b1;
						age_q[req_s1.sensor_sel]  <= '0;
					end
				end
				CMD_TICK: begin
					for (int i = 0; i < 2; i++) begin
						if (age_q[i] < cfg.timeout_ticks) begin
							age_q[i] <= age_q[i] + 1'b1;
						end
					end
				end
				CMD_EVAL: begin
					fan_q <= fan_next;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (do_s1 && is_eval_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_s1 && is_eval_s1) begin
			res_s2.fan_running   <= fan_next;
			res_s2.fan_duty      <= fan_next ? cfg.run_duty : '0;
			res_s2.status        <= status_next;
			res_s2.outdoor_fresh <= out_ok;
			res_s2.indoor_fresh  <= in_ok;
		end
	end

	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

endmodule

// ----- hdl/hdfh_cfg.sv -----
// ---------------------------------------------------------------------------
// hdfh_cfg
// Configuration register file: thresholds, timeout and run duty.
// ---------------------------------------------------------------------------
module hdfh_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hdfh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hdfh_pkg::CFG_DATA_W-1:0] cfg_data,
	output hdfh_pkg::cfg_t                 cfg
);
	import hdfh_pkg::*;

	cfg_t cfg_q;

	// Each write lands in the register its index selects, truncated to width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_threshold  <= ON_THR_RST;
			cfg_q.off_threshold <= OFF_THR_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.run_duty      <= DUTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ON_THR:  cfg_q.on_threshold  <= cfg_data[THR_W-1:0];
				REG_OFF_THR: cfg_q.off_threshold <= cfg_data[THR_W-1:0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data[TICKS_W-1:0];
				REG_DUTY:    cfg_q.run_duty      <= cfg_data[DUTY_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/hdfh_checker.sv -----
// ---------------------------------------------------------------------------
// hdfh_checker
// Port-level checks of the fan controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hdfh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input hdfh_pkg::out_t                  out_data
);
	import hdfh_pkg::*;

	// A stalled result stays presented and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// A running status is reported exactly when the fan runs.
	`ASSERT_IMPL(a_run_status, clk, arst_n, out_valid, (out_data.status == ST_RUNNING) == out_data.fan_running)

	// The fan only runs with both sensors fresh.
	`ASSERT_IMPL(a_run_fresh, clk, arst_n, out_valid && out_data.fan_running, out_data.outdoor_fresh && out_data.indoor_fresh)

	// A stopped fan gives zero duty.
	`ASSERT_IMPL(a_duty_off, clk, arst_n, out_valid && !out_data.fan_running, out_data.fan_duty == '0)

	// A stopped status needs both sensors fresh.
	`ASSERT_IMPL(a_stop_fresh, clk, arst_n, out_valid && (out_data.status == ST_STOPPED), out_data.outdoor_fresh && out_data.indoor_fresh)

endmodule

bind humidity_diff_fan_hysteresis_top hdfh_checker u_hdfh_checker (.*);
